// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cpu_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu_pkg
// character codes, status codes and helpers for the content pattern unescaper
// ----------------------------------------------------------------------------
package cpu_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ESC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic             is_hex;
    logic [NIB_W-1:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_digit_t d;
    d.is_hex = 1'b0;
    d.value  = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.is_hex = 1'b1;
      d.value  = c[NIB_W-1:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d.is_hex = 1'b1;
      d.value  = c[NIB_W-1:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

// ===== src/content_pattern_unescape_core.sv =====
// an accepted input beat is loaded into the result register, which drives its result beat
// throughput: one character per cycle while the output is not stalled, set by the single result register
// a stalled result register still takes a new beat when the output drains in the same cycle
// reset: synchronous, active low; clears the mode and escape flags, the held nibble,
// the error and byte-seen flags and the result valid
// ----------------------------------------------------------------------------
// content_pattern_unescape_core
// decodes rule content pattern text, hex sections and escapes while not stalled, one beat a cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module content_pattern_unescape_core
  import cpu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CHAR_W-1:0]     in_tdata,   // [7:0] char_in
  input  logic                  in_tlast,   // is_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] byte_out, [9:8] status, [15:10] zero
  output logic                  out_tuser,  // byte_valid
  output logic                  out_tlast   // done_res
);

  logic               hex_mode_r, hex_mode_nxt;
  logic               esc_armed_r, esc_armed_nxt;
  logic               nib_held_r, nib_held_nxt;
  logic [NIB_W-1:0]   high_nib_r, high_nib_nxt;
  logic               err_seen_r, err_seen_nxt;
  logic               any_byte_r, any_byte_nxt;

  logic               out_valid_r;
  logic [CHAR_W-1:0]  byte_r, byte_nxt;
  logic               bvalid_r, bvalid_nxt;
  logic               last_r;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic               in_fire;
  hex_digit_t         hd;
  logic               err_upd, any_upd;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign hd        = hex_decode(in_tdata);

  always_comb begin
    hex_mode_nxt  = hex_mode_r;
    esc_armed_nxt = esc_armed_r;
    nib_held_nxt  = nib_held_r;
    high_nib_nxt  = high_nib_r;
    err_upd       = err_seen_r;
    byte_nxt      = '0;
    bvalid_nxt    = 1'b0;
    status_nxt    = ST_OK;
    priority if (in_tdata == CH_PIPE) begin
      hex_mode_nxt = !hex_mode_r;
    end else if (!esc_armed_r && in_tdata == CH_BSLASH) begin
      esc_armed_nxt = 1'b1;
    end else if (hex_mode_r) begin
      if (hd.is_hex) begin
        if (nib_held_r) begin
          byte_nxt     = {high_nib_r, hd.value};
          bvalid_nxt   = 1'b1;
          nib_held_nxt = 1'b0;
        end else begin
          high_nib_nxt = hd.value;
          nib_held_nxt = 1'b1;
        end
      end
    end else if (esc_armed_r) begin
      if (in_tdata == CH_COLON || in_tdata == CH_SEMI ||
          in_tdata == CH_BSLASH || in_tdata == CH_DQUOTE) begin
        byte_nxt   = in_tdata;
        bvalid_nxt = 1'b1;
      end else begin
        err_upd = 1'b1;
      end
      esc_armed_nxt = 1'b0;
    end else begin
      byte_nxt   = in_tdata;
      bvalid_nxt = 1'b1;
    end
    any_upd = any_byte_r || bvalid_nxt;
    if (in_tlast) begin
      if (err_upd) begin
        status_nxt = ST_BAD_ESC;
      end else if (!any_upd) begin
        status_nxt = ST_EMPTY;
      end
    end
    // end of pattern starts the next one from scratch
    err_seen_nxt = err_upd;
    any_byte_nxt = any_upd;
    if (in_tlast) begin
      hex_mode_nxt  = 1'b0;
      esc_armed_nxt = 1'b0;
      nib_held_nxt  = 1'b0;
      high_nib_nxt  = '0;
      err_seen_nxt  = 1'b0;
      any_byte_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_mode_r  <= 1'b0;
      esc_armed_r <= 1'b0;
      nib_held_r  <= 1'b0;
      high_nib_r  <= '0;
      err_seen_r  <= 1'b0;
      any_byte_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        hex_mode_r  <= hex_mode_nxt;
        esc_armed_r <= esc_armed_nxt;
        nib_held_r  <= nib_held_nxt;
        high_nib_r  <= high_nib_nxt;
        err_seen_r  <= err_seen_nxt;
        any_byte_r  <= any_byte_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r   <= byte_nxt;
      bvalid_r <= bvalid_nxt;
      last_r   <= in_tlast;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-CHAR_W-STATUS_W){1'b0}}, status_r, byte_r};
  assign out_tuser  = bvalid_r;
  assign out_tlast  = last_r;

  `ASSERT_SAME(a_status_only_at_end, out_valid_r && !last_r, status_r == ST_OK,
    "status set on a beat that is not the last")
  `ASSERT_SAME(a_no_byte_is_zero, out_valid_r && !bvalid_r, byte_r == '0,
    "byte_out nonzero without byte_valid")
  `ASSERT_NEXT(a_last_clears_state, in_fire && in_tlast,
    !hex_mode_r && !esc_armed_r && !nib_held_r && !err_seen_r && !any_byte_r,
    "pattern state not cleared after last beat")
  `ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r,
    "accepted beat produced no result")

endmodule
